// ===== hdl/bvc_pkg.sv =====
// Shared types and constants for the band vote cluster unit.
`default_nettype none
package bvc_pkg;

	localparam int TOP_W    = 12;
	localparam int HEIGHT_W = 12;
	localparam int BOT_W    = 13;
	localparam int CFG_W    = 6;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W    = 13;
	localparam int VOTES_W  = 10;
	localparam int STATUS_W = 2;

	localparam logic [VOTES_W-1:0] VOTES_OUT_MAX = '1;
	localparam logic [OUT_W-1:0]   LOWER_MAX     = '1;

	localparam logic [CFG_W-1:0] TOLERANCE_RST     = 6'd5;
	localparam logic [CFG_W-1:0] TOP_MARGIN_RST    = 6'd5;
	localparam logic [CFG_W-1:0] BOTTOM_MARGIN_RST = 6'd3;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_MARGIN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_MARGIN = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [TOP_W-1:0]    box_top;
		logic [HEIGHT_W-1:0] box_height;
		logic                last_box;
	} box_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] band_upper;
		logic [OUT_W-1:0]        band_lower;
		logic [VOTES_W-1:0]      winning_votes;
		logic [STATUS_W-1:0]     status;
	} band_t;

	typedef struct packed {
		logic               vld;
		logic               empty;
		logic               ovf;
		logic [TOP_W-1:0]   top;
		logic [BOT_W-1:0]   bottom;
		logic [VOTES_W-1:0] votes;
	} winner_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_RANK
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/bvc_table.sv =====
// Band type table: one write port, one registered read port.
`default_nettype none
module bvc_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 35
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/bvc_scan.sv =====
// Table scan sequencer: match and vote, insert new types, rank the winner.
`default_nettype none
module bvc_scan #(
	parameter int MAX_TYPES  = 16,
	parameter int VOTE_WIDTH = 10,
	parameter int AW         = 4,
	parameter int CW         = 5,
	parameter int DW         = 35
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire bvc_pkg::box_t             box,
	input  wire logic [bvc_pkg::CFG_W-1:0] tolerance,
	output logic                           busy,
	output logic                           we,
	output logic      [AW-1:0]             waddr,
	output logic      [DW-1:0]             wdata,
	output logic      [AW-1:0]             raddr,
	input  wire logic [DW-1:0]             rdata,
	output bvc_pkg::winner_t               winner
);

	localparam int TW  = bvc_pkg::TOP_W;
	localparam int BW  = bvc_pkg::BOT_W;
	localparam int VXW = (VOTE_WIDTH > bvc_pkg::VOTES_W) ? VOTE_WIDTH : bvc_pkg::VOTES_W;

	bvc_pkg::state_t state_q, state_d;

	logic [TW-1:0]         box_top_q;
	logic [BW-1:0]         box_bot_q;
	logic                  last_q;
	logic [CW-1:0]         ptr_q;
	logic [CW-1:0]         used_q;
	logic                  ovf_q;
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_idx_s1;
	logic [TW-1:0]         best_top_q;
	logic [BW-1:0]         best_bot_q;
	logic [VOTE_WIDTH-1:0] best_votes_q;
	logic                  have_q;

	logic [TW-1:0]         ent_top;
	logic [BW-1:0]         ent_bot;
	logic [VOTE_WIDTH-1:0] ent_votes;
	logic [BW-1:0]         d_top;
	logic [BW-1:0]         d_bot;
	logic                  hit;
	logic                  issue;
	logic                  drained;
	logic                  room;
	logic                  take;
	logic [VOTE_WIDTH-1:0] votes_inc;
	logic [VXW-1:0]        best_ext;

	assign {ent_top, ent_bot, ent_votes} = rdata;

	always_comb begin
		d_top = ({1'b0, ent_top} >= {1'b0, box_top_q}) ?
			{1'b0, ent_top} - {1'b0, box_top_q} : {1'b0, box_top_q} - {1'b0, ent_top};
		d_bot = (ent_bot >= box_bot_q) ? ent_bot - box_bot_q : box_bot_q - ent_bot;
	end

	assign hit       = (d_top <= BW'(tolerance)) && (d_bot <= BW'(tolerance));
	assign issue     = (ptr_q < used_q);
	assign drained   = !issue && !rd_vld_s1;
	assign room      = (used_q < CW'(MAX_TYPES));
	assign take      = !have_q || (ent_votes > best_votes_q);
	assign votes_inc = (&ent_votes) ? ent_votes : ent_votes + VOTE_WIDTH'(1);
	assign raddr     = ptr_q[AW-1:0];
	assign busy      = (state_q != bvc_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = rd_idx_s1;
		wdata   = {box_top_q, box_bot_q, votes_inc};
		unique case (state_q)
			bvc_pkg::ST_IDLE: begin
				if (go) begin
					state_d = bvc_pkg::ST_MATCH;
				end
			end
			bvc_pkg::ST_MATCH: begin
				if (rd_vld_s1 && hit) begin
					we      = 1'b1;
					wdata   = {ent_top, ent_bot, votes_inc};
					state_d = last_q ? bvc_pkg::ST_RANK : bvc_pkg::ST_IDLE;
				end else if (drained) begin
					we      = room;
					waddr   = used_q[AW-1:0];
					wdata   = {box_top_q, box_bot_q, VOTE_WIDTH'(1)};
					state_d = last_q ? bvc_pkg::ST_RANK : bvc_pkg::ST_IDLE;
				end
			end
			bvc_pkg::ST_RANK: begin
				if (drained) begin
					state_d = bvc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bvc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			ovf_q     <= 1'b0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			have_q    <= 1'b0;
		end else begin
			if (state_q == bvc_pkg::ST_IDLE) begin
				ptr_q     <= '0;
				rd_vld_s1 <= 1'b0;
				have_q    <= 1'b0;
			end else if (state_d != state_q) begin
				ptr_q     <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				ptr_q     <= ptr_q + CW'(issue);
				rd_vld_s1 <= issue;
			end
			if (state_q == bvc_pkg::ST_MATCH && !(rd_vld_s1 && hit) && drained) begin
				if (room) begin
					used_q <= used_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == bvc_pkg::ST_RANK) begin
				if (drained) begin
					used_q <= '0;
					ovf_q  <= 1'b0;
				end else if (rd_vld_s1 && take) begin
					have_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q[AW-1:0];
		if (state_q == bvc_pkg::ST_IDLE && go) begin
			box_top_q <= box.box_top;
			box_bot_q <= {1'b0, box.box_top} + {1'b0, box.box_height};
			last_q    <= box.last_box;
		end
		if (state_q == bvc_pkg::ST_RANK && rd_vld_s1 && take) begin
			best_top_q   <= ent_top;
			best_bot_q   <= ent_bot;
			best_votes_q <= ent_votes;
		end
	end

	assign best_ext = VXW'(best_votes_q);

	always_comb begin
		winner.vld    = (state_q == bvc_pkg::ST_RANK) && drained;
		winner.empty  = !have_q;
		winner.ovf    = ovf_q;
		winner.top    = best_top_q;
		winner.bottom = best_bot_q;
		winner.votes  = (best_ext > VXW'(bvc_pkg::VOTES_OUT_MAX)) ?
			bvc_pkg::VOTES_OUT_MAX : best_ext[bvc_pkg::VOTES_W-1:0];
	end

endmodule
`default_nettype wire

// ===== hdl/band_vote_cluster_unit.sv =====
// Band vote cluster unit: top level with registers, result stage and checks.
// A box holds busy while the scan reads the table, one table entry read per cycle. A last
// box then ranks the table entries over the same read port; band_valid pulses for one
// cycle right after busy falls. The unit takes one box per busy period and accepts no
// new box while busy.
// Reset clears the type count, the overflow flag and the registers to 5, 5 and 3;
// table entries need no clearing. The receiver cannot stall the result.
`default_nettype none
module band_vote_cluster_unit #(
	parameter int MAX_TYPES  = 16,
	parameter int VOTE_WIDTH = 10
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire bvc_pkg::box_t                 box,
	output logic                               band_valid,
	output bvc_pkg::band_t                     band,
	input  wire logic                          cfg_we,
	input  wire logic [bvc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bvc_pkg::CFG_W-1:0]     cfg_data
);

	localparam int AW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
	localparam int CW = $clog2(MAX_TYPES + 1);
	localparam int DW = bvc_pkg::TOP_W + bvc_pkg::BOT_W + VOTE_WIDTH;
	localparam int OW = bvc_pkg::OUT_W;

	logic [bvc_pkg::CFG_W-1:0] tolerance_q;
	logic [bvc_pkg::CFG_W-1:0] top_margin_q;
	logic [bvc_pkg::CFG_W-1:0] bottom_margin_q;

	logic             go;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [DW-1:0]    wdata;
	logic [AW-1:0]    raddr;
	logic [DW-1:0]    rdata;
	bvc_pkg::winner_t winner;
	logic [OW:0]      lower_sum;
	logic             band_valid_q;
	bvc_pkg::band_t   band_q;

	assign go = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q     <= bvc_pkg::TOLERANCE_RST;
			top_margin_q    <= bvc_pkg::TOP_MARGIN_RST;
			bottom_margin_q <= bvc_pkg::BOTTOM_MARGIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bvc_pkg::REG_TOLERANCE:     tolerance_q     <= cfg_data;
				bvc_pkg::REG_TOP_MARGIN:    top_margin_q    <= cfg_data;
				bvc_pkg::REG_BOTTOM_MARGIN: bottom_margin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bvc_table #(
		.DEPTH (MAX_TYPES),
		.AW    (AW),
		.DW    (DW)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	bvc_scan #(
		.MAX_TYPES  (MAX_TYPES),
		.VOTE_WIDTH (VOTE_WIDTH),
		.AW         (AW),
		.CW         (CW),
		.DW         (DW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.box       (box),
		.tolerance (tolerance_q),
		.busy      (busy),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr     (raddr),
		.rdata     (rdata),
		.winner    (winner)
	);

	assign lower_sum = {1'b0, winner.bottom} + (OW + 1)'(bottom_margin_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_valid_q <= 1'b0;
		end else begin
			band_valid_q <= winner.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (winner.vld) begin
			if (winner.empty) begin
				band_q.band_upper    <= '0;
				band_q.band_lower    <= '0;
				band_q.winning_votes <= '0;
				band_q.status        <= bvc_pkg::STAT_EMPTY;
			end else begin
				band_q.band_upper    <= $signed({1'b0, winner.top} - OW'(top_margin_q));
				band_q.band_lower    <= lower_sum[OW] ? bvc_pkg::LOWER_MAX : lower_sum[OW-1:0];
				band_q.winning_votes <= winner.votes;
				band_q.status        <= winner.ovf ? bvc_pkg::STAT_OVERFLOW : bvc_pkg::STAT_OK;
			end
		end
	end

	assign band_valid = band_valid_q;
	assign band       = band_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		band_valid |-> $past(busy) && !$past(start && !busy))
		else $error("result strobe without a finished scan");

	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		band_valid |-> band.status != bvc_pkg::STAT_EMPTY)
		else $error("result reports an empty table after a counted box");

endmodule
`default_nettype wire
